// ----- design/qtr_pkg.sv -----
// ----------------------------------------------------------------------------
// qtr_pkg
// shared types and constants of the quad texture rasterizer
// ----------------------------------------------------------------------------
package qtr_pkg;

    localparam int TEX_WIDTH   = 64;
    localparam int TEX_HEIGHT  = 64;
    localparam int SCREEN_SIZE = 1024;
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = 12;
    localparam int FRAC_BITS   = 20;

    localparam int COORD_W = 12;               // corner coordinate
    localparam int PIX_W   = 10;               // screen coordinate
    localparam int DIFF_W  = 13;               // vertex difference
    localparam int PROD_W  = 2 * DIFF_W;       // one edge product
    localparam int XP_W    = PROD_W + 1;       // cross product
    localparam int MAG_W   = 26;               // |den|, and nu, nv on a hit
    localparam int Q_W     = FRAC_BITS + 1;    // barycentric in [0,1]
    localparam int ACC_W   = Q_W + 11;         // scaled texel coordinate
    localparam int TC_W    = ACC_W - FRAC_BITS;

    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_C0X = 3'd0;
    localparam logic [IDX_W-1:0] REG_C0Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_C1X = 3'd2;
    localparam logic [IDX_W-1:0] REG_C1Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_C2X = 3'd4;
    localparam logic [IDX_W-1:0] REG_C2Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_C3X = 3'd6;
    localparam logic [IDX_W-1:0] REG_C3Y = 3'd7;

    // input word kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef logic signed [3:0][COORD_W-1:0] corners_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] texel_address;
        logic [7:0]        texel_byte0;
        logic [7:0]        texel_byte1;
        logic [7:0]        texel_byte2;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
    } in_word_t;

    typedef struct packed {
        logic       covered;
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
    } out_word_t;

    // control travelling alongside the datapath
    typedef struct packed {
        logic              valid;
        logic              is_pix;
        logic              hit;
        logic              tri_b;
        logic [ADDR_W-1:0] waddr;
        logic [23:0]       wdata;
    } ctl_t;

endpackage

// ----- design/qtr_edge_setup.sv -----
// ----------------------------------------------------------------------------
// qtr_edge_setup
// edge products, cross products and containment test for both triangles
// ----------------------------------------------------------------------------
module qtr_edge_setup
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  qtr_pkg::in_word_t           in_data,
    input  qtr_pkg::corners_t           cx,
    input  qtr_pkg::corners_t           cy,
    output qtr_pkg::ctl_t               ctl,
    output logic [qtr_pkg::MAG_W-1:0]   num_u,
    output logic [qtr_pkg::MAG_W-1:0]   num_v,
    output logic [qtr_pkg::MAG_W-1:0]   den
);

    typedef struct packed {
        logic signed [qtr_pkg::PROD_W-1:0] d1;
        logic signed [qtr_pkg::PROD_W-1:0] d2;
        logic signed [qtr_pkg::PROD_W-1:0] u1;
        logic signed [qtr_pkg::PROD_W-1:0] u2;
        logic signed [qtr_pkg::PROD_W-1:0] v1;
        logic signed [qtr_pkg::PROD_W-1:0] v2;
    } prod_t;

    typedef struct packed {
        logic signed [qtr_pkg::XP_W-1:0] den;
        logic signed [qtr_pkg::XP_W-1:0] nu;
        logic signed [qtr_pkg::XP_W-1:0] nv;
    } xp_t;

    prod_t [1:0]        prod_reg, prod_next;
    xp_t   [1:0]        xp_reg, xp_next;
    qtr_pkg::ctl_t      ctl1_reg, ctl1_next, ctl2_reg, ctl3_reg, ctl3_next;
    logic               off1_reg, off1_next, off2_reg;
    logic [qtr_pkg::MAG_W-1:0] nu_reg, nu_next, nv_reg, nv_next, den_reg, den_next;

    // stage 1: vertex differences and the six products of each triangle
    always_comb
    begin
        logic signed [qtr_pkg::DIFF_W-1:0] qx, qy, ex, ey, fx, fy, gx, gy;
        int a;
        qx = $signed({3'b000, in_data.pixel_x});
        qy = $signed({3'b000, in_data.pixel_y});
        for (int t = 0; t < 2; t++)
        begin
            // triangle a is (c0,c1,c2), triangle b is (c3,c1,c2)
            // corner elements select as unsigned, so re-sign before extending
            a  = (t == 0) ? 0 : 3;
            ex = qtr_pkg::DIFF_W'($signed(cx[2])) - qtr_pkg::DIFF_W'($signed(cx[a]));
            ey = qtr_pkg::DIFF_W'($signed(cy[2])) - qtr_pkg::DIFF_W'($signed(cy[a]));
            fx = qtr_pkg::DIFF_W'($signed(cx[1])) - qtr_pkg::DIFF_W'($signed(cx[a]));
            fy = qtr_pkg::DIFF_W'($signed(cy[1])) - qtr_pkg::DIFF_W'($signed(cy[a]));
            gx = qx - qtr_pkg::DIFF_W'($signed(cx[a]));
            gy = qy - qtr_pkg::DIFF_W'($signed(cy[a]));
            prod_next[t].d1 = ex * fy;
            prod_next[t].d2 = ey * fx;
            prod_next[t].u1 = gx * fy;
            prod_next[t].u2 = gy * fx;
            prod_next[t].v1 = ex * gy;
            prod_next[t].v2 = ey * gx;
        end
        off1_next = (32'(in_data.pixel_x) >= qtr_pkg::SCREEN_SIZE)
                 || (32'(in_data.pixel_y) >= qtr_pkg::SCREEN_SIZE);
        ctl1_next.valid  = in_valid;
        ctl1_next.is_pix = (in_data.kind == qtr_pkg::KIND_PIXEL);
        ctl1_next.hit    = 1'b0;
        ctl1_next.tri_b  = 1'b0;
        ctl1_next.waddr  = in_data.texel_address;
        ctl1_next.wdata  = {in_data.texel_byte2, in_data.texel_byte1, in_data.texel_byte0};
    end

    // stage 2: cross products, oriented so that den is never negative
    always_comb
    begin
        logic signed [qtr_pkg::XP_W-1:0] d, u, v;
        for (int t = 0; t < 2; t++)
        begin
            d = qtr_pkg::XP_W'(prod_reg[t].d1) - qtr_pkg::XP_W'(prod_reg[t].d2);
            u = qtr_pkg::XP_W'(prod_reg[t].u1) - qtr_pkg::XP_W'(prod_reg[t].u2);
            v = qtr_pkg::XP_W'(prod_reg[t].v1) - qtr_pkg::XP_W'(prod_reg[t].v2);
            if (d < 0)
            begin
                xp_next[t].den = -d;
                xp_next[t].nu  = -u;
                xp_next[t].nv  = -v;
            end
            else
            begin
                xp_next[t].den = d;
                xp_next[t].nu  = u;
                xp_next[t].nv  = v;
            end
        end
    end

    // stage 3: containment, first triangle wins
    always_comb
    begin
        logic [1:0] in_tri;
        logic signed [qtr_pkg::XP_W:0] s;
        for (int t = 0; t < 2; t++)
        begin
            s = (qtr_pkg::XP_W+1)'(xp_reg[t].nu) + (qtr_pkg::XP_W+1)'(xp_reg[t].nv);
            in_tri[t] = (xp_reg[t].den != '0) && (xp_reg[t].nu >= 0)
                     && (xp_reg[t].nv >= 0) && (s <= (qtr_pkg::XP_W+1)'(xp_reg[t].den));
        end
        ctl3_next       = ctl2_reg;
        ctl3_next.hit   = ctl2_reg.is_pix && !off2_reg && (in_tri != 2'b00);
        ctl3_next.tri_b = !in_tri[0];
        if (in_tri[0])
        begin
            nu_next  = xp_reg[0].nu[qtr_pkg::MAG_W-1:0];
            nv_next  = xp_reg[0].nv[qtr_pkg::MAG_W-1:0];
            den_next = xp_reg[0].den[qtr_pkg::MAG_W-1:0];
        end
        else
        begin
            nu_next  = xp_reg[1].nu[qtr_pkg::MAG_W-1:0];
            nv_next  = xp_reg[1].nv[qtr_pkg::MAG_W-1:0];
            den_next = xp_reg[1].den[qtr_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            off1_reg <= off1_next;
            xp_reg   <= xp_next;
            off2_reg <= off1_reg;
            nu_reg   <= nu_next;
            nv_reg   <= nv_next;
            den_reg  <= den_next;
        end
    end

    assign ctl   = ctl3_reg;
    assign num_u = nu_reg;
    assign num_v = nv_reg;
    assign den   = den_reg;

endmodule

// ----- design/qtr_div_pipe.sv -----
// ----------------------------------------------------------------------------
// qtr_div_pipe
// pipelined restoring divider, one quotient bit per stage, u and v together
// ----------------------------------------------------------------------------
module qtr_div_pipe
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  qtr_pkg::ctl_t               ctl_in,
    input  logic [qtr_pkg::MAG_W-1:0]   num_u,
    input  logic [qtr_pkg::MAG_W-1:0]   num_v,
    input  logic [qtr_pkg::MAG_W-1:0]   den,
    output qtr_pkg::ctl_t               ctl_out,
    output logic [qtr_pkg::Q_W-1:0]     quo_u,
    output logic [qtr_pkg::Q_W-1:0]     quo_v
);

    localparam int N = qtr_pkg::Q_W;
    localparam int M = qtr_pkg::MAG_W;

    qtr_pkg::ctl_t [N-1:0]  ctl_reg;
    logic [N-1:0][M-1:0]    den_reg;
    logic [N-1:0][M-1:0]    ru_reg, ru_next, rv_reg, rv_next;
    logic [N-1:0][N-1:0]    qu_reg, qu_next, qv_reg, qv_next;

    always_comb
    begin
        logic [M:0] tu, tv, dd;
        logic       bu, bv;
        // first stage: numerator is at most den, so no doubling
        dd = {1'b0, den};
        tu = {1'b0, num_u};
        tv = {1'b0, num_v};
        bu = (tu >= dd);
        bv = (tv >= dd);
        ru_next[0] = M'(bu ? tu - dd : tu);
        rv_next[0] = M'(bv ? tv - dd : tv);
        qu_next[0] = N'(bu);
        qv_next[0] = N'(bv);
        for (int k = 1; k < N; k++)
        begin
            dd = {1'b0, den_reg[k-1]};
            tu = {ru_reg[k-1], 1'b0};
            tv = {rv_reg[k-1], 1'b0};
            bu = (tu >= dd);
            bv = (tv >= dd);
            ru_next[k] = M'(bu ? tu - dd : tu);
            rv_next[k] = M'(bv ? tv - dd : tv);
            qu_next[k] = {qu_reg[k-1][N-2:0], bu};
            qv_next[k] = {qv_reg[k-1][N-2:0], bv};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= {ctl_reg[N-2:0], ctl_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= {den_reg[N-2:0], den};
            ru_reg  <= ru_next;
            rv_reg  <= rv_next;
            qu_reg  <= qu_next;
            qv_reg  <= qv_next;
        end
    end

    assign ctl_out = ctl_reg[N-1];
    assign quo_u   = qu_reg[N-1];
    assign quo_v   = qv_reg[N-1];

endmodule

// ----- design/qtr_texel_store.sv -----
// ----------------------------------------------------------------------------
// qtr_texel_store
// texel coordinate scaling, address forming and the texture memory
// ----------------------------------------------------------------------------
module qtr_texel_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  qtr_pkg::ctl_t               ctl_in,
    input  logic [qtr_pkg::Q_W-1:0]     quo_u,
    input  logic [qtr_pkg::Q_W-1:0]     quo_v,
    output qtr_pkg::ctl_t               ctl_out,
    output logic [23:0]                 rdata
);

    localparam int AW = qtr_pkg::ACC_W;

    qtr_pkg::ctl_t              ctl1_reg, ctl2_reg, ctl3_reg;
    logic [AW-1:0]              px_reg, px_next, py_reg, py_next;
    logic [qtr_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [23:0]                rdata_reg;
    logic [23:0]                mem [qtr_pkg::STORE_DEPTH];

    // triangle a: x follows v, y follows u; triangle b mirrors from corner 3
    always_comb
    begin
        logic [qtr_pkg::Q_W-1:0] qx, qy;
        qx = ctl_in.tri_b ? quo_u : quo_v;
        qy = ctl_in.tri_b ? quo_v : quo_u;
        px_next = AW'(qx) * AW'(qtr_pkg::TEX_WIDTH - 1);
        py_next = AW'(qy) * AW'(qtr_pkg::TEX_HEIGHT - 1);
    end

    always_comb
    begin
        logic [AW-1:0]  ax, ay;
        logic [31:0]    lin;
        if (ctl1_reg.tri_b)
        begin
            ax = (AW'(qtr_pkg::TEX_WIDTH - 1) << qtr_pkg::FRAC_BITS) - px_reg;
            ay = (AW'(qtr_pkg::TEX_HEIGHT - 1) << qtr_pkg::FRAC_BITS) - py_reg;
        end
        else
        begin
            ax = px_reg;
            ay = py_reg;
        end
        lin = 32'(ay[AW-1:qtr_pkg::FRAC_BITS]) * qtr_pkg::TEX_WIDTH
            + 32'(ax[AW-1:qtr_pkg::FRAC_BITS]);
        addr_next = ctl1_reg.is_pix ? lin[qtr_pkg::ADDR_W-1:0] : ctl1_reg.waddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            addr_reg <= addr_next;
        end
    end

    // writes and reads meet the memory in order, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ctl2_reg.valid && !ctl2_reg.is_pix)
            begin
                mem[addr_reg] <= ctl2_reg.wdata;
            end
            rdata_reg <= mem[addr_reg];
        end
    end

    assign ctl_out = ctl3_reg;
    assign rdata   = rdata_reg;

endmodule

// ----- design/quad_texture_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// quad_texture_rasterizer_unit
// maps a stored texture onto a projected quad, one pixel query per word
// ----------------------------------------------------------------------------
// the quad's four corners are set through the register port (ready is always
// high); the user must set them only while the unit is idle (not enforced).
// an input word either writes one texel (kind 0, no result) or asks for one
// screen pixel (kind 1, one result word). the unit takes one word per clock;
// the whole pipeline holds while the output word is stalled; a pixel passes
// 3 setup stages (edge products, cross products, containment), 21 stages of
// the pipelined divider that form the barycentrics u and v one bit per
// stage, 2 stages of texel scaling and address forming, the texture memory
// read and the output register. texel writes pass the same pipeline and
// reach the memory in order with reads, so a pixel always sees every texel
// written before it. a pixel that falls in neither triangle returns covered
// low and zero bytes; texels never written read back undefined.
// ----------------------------------------------------------------------------
module quad_texture_rasterizer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  qtr_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qtr_pkg::out_word_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qtr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [qtr_pkg::COORD_W-1:0]   cfg_data
);

    qtr_pkg::corners_t          cx_reg, cy_reg;
    qtr_pkg::ctl_t              ctl_s, ctl_d, ctl_m;
    logic [qtr_pkg::MAG_W-1:0]  num_u, num_v, den;
    logic [qtr_pkg::Q_W-1:0]    quo_u, quo_v;
    logic [23:0]                rdata;
    logic                       en;
    logic                       out_valid_reg;
    qtr_pkg::out_word_t         out_data_reg, out_data_next;

    // pipeline moves whenever the output slot is free or being taken
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // corner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qtr_pkg::REG_C0X: cx_reg[0] <= cfg_data;
                qtr_pkg::REG_C0Y: cy_reg[0] <= cfg_data;
                qtr_pkg::REG_C1X: cx_reg[1] <= cfg_data;
                qtr_pkg::REG_C1Y: cy_reg[1] <= cfg_data;
                qtr_pkg::REG_C2X: cx_reg[2] <= cfg_data;
                qtr_pkg::REG_C2Y: cy_reg[2] <= cfg_data;
                qtr_pkg::REG_C3X: cx_reg[3] <= cfg_data;
                qtr_pkg::REG_C3Y: cy_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    qtr_edge_setup u_setup
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (in_data),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .ctl      (ctl_s),
        .num_u    (num_u),
        .num_v    (num_v),
        .den      (den)
    );

    qtr_div_pipe u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_s),
        .num_u   (num_u),
        .num_v   (num_v),
        .den     (den),
        .ctl_out (ctl_d),
        .quo_u   (quo_u),
        .quo_v   (quo_v)
    );

    qtr_texel_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_d),
        .quo_u   (quo_u),
        .quo_v   (quo_v),
        .ctl_out (ctl_m),
        .rdata   (rdata)
    );

    // result word: bytes 0 and 2 swapped, zero on a miss
    always_comb
    begin
        out_data_next.covered = ctl_m.hit;
        if (ctl_m.hit)
        begin
            out_data_next.out_byte0 = rdata[23:16];
            out_data_next.out_byte1 = rdata[15:8];
            out_data_next.out_byte2 = rdata[7:0];
        end
        else
        begin
            out_data_next.out_byte0 = '0;
            out_data_next.out_byte1 = '0;
            out_data_next.out_byte2 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_m.valid && ctl_m.is_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for quad_texture_rasterizer_unit: a directed table at
// reset, then random texel writes and pixel queries under several corner
// settings, each result checked against a typed-in expectation or a predictor
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import qtr_pkg::*;

    localparam int  FILL_GUARD  = 40;      // pipeline is 28 deep
    localparam int  RAND_WORDS  = 110;     // per corner setting
    localparam int  NUM_PHASES  = 8;

    // one row of the directed table
    typedef struct {
        in_word_t  word;
        bit        fixed;       // expectation typed in below
        out_word_t result;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [COORD_W-1:0] cfg_data;

    // shadow of the unit: corner registers and texture memory
    longint     corner_x [4];
    longint     corner_y [4];
    logic [23:0] texels [STORE_DEPTH];
    bit         written [STORE_DEPTH];

    out_word_t  pending_pixels [$];
    int         fail_count;
    bit         no_stall_mode;

    quad_texture_rasterizer_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // barycentric hit test for triangle (a origin, b, c); u along c-a, v along b-a
    function automatic bit in_triangle(input int a, input int b, input int c,
                                       input longint qx, input longint qy,
                                       output longint uq, output longint vq);
        longint ex, ey, fx, fy, gx, gy, den, nu, nv;
        ex = corner_x[c] - corner_x[a];
        ey = corner_y[c] - corner_y[a];
        fx = corner_x[b] - corner_x[a];
        fy = corner_y[b] - corner_y[a];
        gx = qx - corner_x[a];
        gy = qy - corner_y[a];
        den = ex * fy - ey * fx;
        nu  = gx * fy - gy * fx;
        nv  = ex * gy - ey * gx;
        uq = 0;
        vq = 0;
        // degenerate triangle never hits
        if (den == 0)
            return 0;
        if (den < 0)
        begin
            den = -den;
            nu  = -nu;
            nv  = -nv;
        end
        if (nu < 0 || nv < 0 || nu + nv > den)
            return 0;
        uq = (nu <<< FRAC_BITS) / den;
        vq = (nv <<< FRAC_BITS) / den;
        return 1;
    endfunction

    // affine texel coordinate, clamped to the texture, truncated
    function automatic longint texel_coord(input longint base, input longint du,
                                           input longint dv, input longint uq,
                                           input longint vq, input longint size);
        longint acc, top;
        acc = (base <<< FRAC_BITS) + uq * du + vq * dv;
        top = (size - 1) <<< FRAC_BITS;
        if (acc < 0)
            acc = 0;
        if (acc > top)
            acc = top;
        return acc >>> FRAC_BITS;
    endfunction

    // expected result word; addr gives the texel read on a hit
    function automatic out_word_t shade_pixel(input logic [PIX_W-1:0] px,
                                              input logic [PIX_W-1:0] py,
                                              output int addr);
        out_word_t r;
        longint uq, vq, tx, ty;
        logic [23:0] t;
        longint wm, hm;
        wm = TEX_WIDTH - 1;
        hm = TEX_HEIGHT - 1;
        r = '0;
        addr = 0;
        if (in_triangle(0, 1, 2, px, py, uq, vq))
        begin
            tx = texel_coord(0, 0, wm, uq, vq, TEX_WIDTH);
            ty = texel_coord(0, hm, 0, uq, vq, TEX_HEIGHT);
        end
        else if (in_triangle(3, 1, 2, px, py, uq, vq))
        begin
            tx = texel_coord(wm, -wm, 0, uq, vq, TEX_WIDTH);
            ty = texel_coord(hm, 0, -hm, uq, vq, TEX_HEIGHT);
        end
        else
            return r;
        addr = int'((ty * TEX_WIDTH + tx) % STORE_DEPTH);
        t = texels[addr];
        r.covered   = 1'b1;
        r.out_byte0 = t[23:16];
        r.out_byte1 = t[15:8];
        r.out_byte2 = t[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // send one word, hold it until taken, then update the shadow
    task automatic send_word(input in_word_t w, input bit burst,
                             input bit fixed, input out_word_t result);
        int gap;
        bit taken;
        int taddr;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        // stall only moves at the rising edge, so look at it mid-cycle
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        if (w.kind == KIND_WRITE)
        begin
            texels[w.texel_address] = {w.texel_byte2, w.texel_byte1, w.texel_byte0};
            written[w.texel_address] = 1'b1;
        end
        else if (fixed)
            pending_pixels.push_back(result);
        else
            pending_pixels.push_back(shade_pixel(w.pixel_x, w.pixel_y, taddr));
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        bit done;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[COORD_W-1:0];
        do
        begin
            @(negedge clk);
            done = cfg_ready;
            @(posedge clk);
        end
        while (!done);
        if (idx[0] == 1'b0)
            corner_x[idx >> 1] = value;
        else
            corner_y[idx >> 1] = value;
    endtask

    task automatic set_corners(input int xs [4], input int ys [4]);
        write_reg(REG_C0X, xs[0]);
        write_reg(REG_C0Y, ys[0]);
        write_reg(REG_C1X, xs[1]);
        write_reg(REG_C1Y, ys[1]);
        write_reg(REG_C2X, xs[2]);
        write_reg(REG_C2Y, ys[2]);
        write_reg(REG_C3X, xs[3]);
        write_reg(REG_C3Y, ys[3]);
        cfg_valid <= 1'b0;
    endtask

    // unit is idle once every result is back and the write tail has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (FILL_GUARD) @(posedge clk);
    endtask

    function automatic in_word_t random_word();
        in_word_t w;
        logic [63:0] r;
        r = {$urandom, $urandom};
        w = in_word_t'(r[$bits(in_word_t)-1:0]);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall, check each accepted word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ($urandom_range(199) == 0)
            no_stall_mode <= !no_stall_mode;
        if (no_stall_mode)
            out_stall <= 1'b0;
        else if ($urandom_range(99) < 25)
            out_stall <= 1'b1;
        else if ($urandom_range(99) < 3)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    // outputs settle after the rising edge; mid-cycle values are what the
    // next edge will take
    always @(negedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result word with nothing expected: %h", out_data);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_data.covered !== want.covered)
                begin
                    $error("covered: expected %0d got %0d", want.covered, out_data.covered);
                    fail_count++;
                end
                if (out_data.out_byte0 !== want.out_byte0)
                begin
                    $error("out_byte0: expected %h got %h", want.out_byte0, out_data.out_byte0);
                    fail_count++;
                end
                if (out_data.out_byte1 !== want.out_byte1)
                begin
                    $error("out_byte1: expected %h got %h", want.out_byte1, out_data.out_byte1);
                    fail_count++;
                end
                if (out_data.out_byte2 !== want.out_byte2)
                begin
                    $error("out_byte2: expected %h got %h", want.out_byte2, out_data.out_byte2);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t row;
        in_word_t  w;
        in_word_t  tw;
        out_word_t miss;
        out_word_t probe;
        int addr;
        int xs [4];
        int ys [4];
        int lo_x, hi_x, lo_y, hi_y;
        bit burst;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        no_stall_mode = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fail_count    = 0;
        for (int i = 0; i < 4; i++)
        begin
            corner_x[i] = 0;
            corner_y[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: all corners at zero, both triangles degenerate,
        // so every pixel misses and reads no texel
        miss = '0;
        row.fixed = 1'b0;
        row.result = miss;
        row.word = '0;
        row.word.kind = KIND_WRITE;
        table_rows.push_back(row);                                  // lowest texel, zero bytes
        row.word = '1;
        row.word.kind = KIND_WRITE;
        table_rows.push_back(row);                                  // highest texel, all ones
        row.word = '0;
        row.word.kind = KIND_WRITE;
        row.word.texel_address = 12'h555;
        row.word.texel_byte0 = 8'hAA;
        row.word.texel_byte1 = 8'h55;
        row.word.texel_byte2 = 8'hAA;
        table_rows.push_back(row);
        row.word.texel_address = 12'hAAA;
        row.word.texel_byte0 = 8'h55;
        row.word.texel_byte1 = 8'hAA;
        row.word.texel_byte2 = 8'h55;
        table_rows.push_back(row);
        row.fixed = 1'b1;
        row.word = '0;
        row.word.kind = KIND_PIXEL;                                 // origin pixel
        table_rows.push_back(row);
        row.word = '1;                                              // far corner, texel bits set
        table_rows.push_back(row);
        row.word = '0;
        row.word.kind = KIND_PIXEL;
        row.word.pixel_x = '1;
        table_rows.push_back(row);
        row.word.pixel_x = '0;
        row.word.pixel_y = '1;
        table_rows.push_back(row);
        row.word.pixel_x = 10'h155;
        row.word.pixel_y = 10'h2AA;
        table_rows.push_back(row);
        row.fixed = 1'b0;                                           // predictor rows
        for (int i = 0; i < 6; i++)
        begin
            row.word = random_word();
            row.word.kind = KIND_PIXEL;
            table_rows.push_back(row);
        end
        foreach (table_rows[i])
            send_word(table_rows[i].word, i[0], table_rows[i].fixed, table_rows[i].result);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // upright square well inside the screen
                    xs = '{100, 900, 100, 900};
                    ys = '{100, 100, 900, 900};
                end
                1:
                begin
                    // register extremes, quad covers the whole screen
                    xs = '{-2048, 2047, -2048, 2047};
                    ys = '{-2048, -2048, 2047, 2047};
                end
                2:
                begin
                    // mirrored: cross product signs opposite to the upright square
                    xs = '{900, 100, 900, 100};
                    ys = '{100, 100, 900, 900};
                end
                3:
                begin
                    // first triangle collinear, second one live
                    xs = '{0, 500, 1000, 40};
                    ys = '{0, 500, 1000, 900};
                end
                4:
                begin
                    // opposite extremes, small texture footprint in the corner
                    xs = '{2047, 10, 2047, -2048};
                    ys = '{2047, 2047, 10, -2048};
                end
                default:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        xs[i] = $urandom_range(1400) - 200;
                        ys[i] = $urandom_range(1400) - 200;
                    end
                end
            endcase
            set_corners(xs, ys);

            // bounding box of the quad on the screen
            lo_x = 1023; hi_x = 0; lo_y = 1023; hi_y = 0;
            for (int i = 0; i < 4; i++)
            begin
                lo_x = (xs[i] < lo_x) ? xs[i] : lo_x;
                hi_x = (xs[i] > hi_x) ? xs[i] : hi_x;
                lo_y = (ys[i] < lo_y) ? ys[i] : lo_y;
                hi_y = (ys[i] > hi_y) ? ys[i] : hi_y;
            end
            lo_x = (lo_x < 0) ? 0 : lo_x;
            lo_y = (lo_y < 0) ? 0 : lo_y;
            hi_x = (hi_x > 1023) ? 1023 : hi_x;
            hi_y = (hi_y > 1023) ? 1023 : hi_y;
            if (lo_x > hi_x || lo_y > hi_y)
            begin
                lo_x = 0; hi_x = 1023; lo_y = 0; hi_y = 1023;
            end

            burst = 1'b0;
            for (int n = 0; n < RAND_WORDS; n++)
            begin
                if ($urandom_range(29) == 0)
                    burst = !burst;
                w = random_word();
                if ($urandom_range(99) < 20)
                    w.kind = KIND_WRITE;
                else
                begin
                    w.kind = KIND_PIXEL;
                    if ($urandom_range(99) < 75)
                    begin
                        w.pixel_x = PIX_W'($urandom_range(hi_x, lo_x));
                        w.pixel_y = PIX_W'($urandom_range(hi_y, lo_y));
                    end
                    // a hit on a texel not yet written gets that texel first
                    probe = shade_pixel(w.pixel_x, w.pixel_y, addr);
                    if (probe.covered && !written[addr])
                    begin
                        tw = random_word();
                        tw.kind = KIND_WRITE;
                        tw.texel_address = addr[ADDR_W-1:0];
                        send_word(tw, burst, 1'b0, miss);
                    end
                end
                send_word(w, burst, 1'b0, miss);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("** quad_texture_rasterizer_unit: PASSED **");
        else
            $display("** quad_texture_rasterizer_unit: FAILED **");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("** quad_texture_rasterizer_unit: FAILED **");
        $finish;
    end

endmodule
